[hw/rtl/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property sampled on the rising clock edge, off while reset is held.
`define ASSERT_CLKD(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: assertion failed");

// A condition that must never be seen on a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	`ASSERT_CLKD(label, clk, rst_n, !(cond))

`endif

[hw/rtl/cnms_pkg.sv]
// ----------------------------------------------------------------------------
// cnms_pkg
// Shared constants for the column null-marker scan: column type codes,
// register indexes and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package cnms_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int TYPE_W     = 3;
	localparam int POS_W      = 16;
	localparam int SKIP_W     = 32;

	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_TYPE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RECORD_LENGTH = 1'b1;

	localparam logic [TYPE_W-1:0] TYPE_BOOL   = 3'd0;
	localparam logic [TYPE_W-1:0] TYPE_INT32  = 3'd1;
	localparam logic [TYPE_W-1:0] TYPE_INT64  = 3'd2;
	localparam logic [TYPE_W-1:0] TYPE_FLOAT  = 3'd3;
	localparam logic [TYPE_W-1:0] TYPE_DOUBLE = 3'd4;
	localparam logic [TYPE_W-1:0] TYPE_STRING = 3'd5;
	localparam logic [TYPE_W-1:0] TYPE_FIXED  = 3'd6;
	localparam logic [TYPE_W-1:0] TYPE_OTHER  = 3'd7;

	localparam logic [POS_W-1:0] FIXED_DEFAULT_LEN = 16'd16;
	localparam logic [31:0]      INT32_MIN_BITS    = 32'h8000_0000;
	localparam logic [63:0]      INT64_MIN_BITS    = 64'h8000_0000_0000_0000;

endpackage

`default_nettype wire

[hw/rtl/cnms_if.sv]
// ----------------------------------------------------------------------------
// cnms_if
// Valid/ready channels of the column null-marker scan: byte requests in,
// null reports out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cnms_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       empty_buffer;

	modport source (output valid, output data_byte, output last_byte,
		output empty_buffer, input ready);
	modport sink (input valid, input data_byte, input last_byte,
		input empty_buffer, output ready);
endinterface

interface cnms_out_if;
	logic valid;
	logic ready;
	logic null_seen;

	modport source (output valid, output null_seen, input ready);
	modport sink (input valid, input null_seen, output ready);
endinterface

`default_nettype wire

[hw/rtl/column_null_marker_scan_core.sv]
// ----------------------------------------------------------------------------
// column_null_marker_scan_core
// Byte-serial null-marker scan over one column buffer per request sequence.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle and updates its scan state in the
// same cycle; the report for a buffer is registered into the output buffer when
// its final byte (or an empty-buffer request) is accepted. Reports pass through
// a two-entry output buffer, so input requests keep flowing while a report
// waits; the input stalls only when both entries are full. There is no start-up
// pass after reset. Configuration writes belong between buffers.
`default_nettype none

module column_null_marker_scan_core import cnms_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	cnms_in_if.sink                    item,
	cnms_out_if.source                 result
);

	logic [TYPE_W-1:0] column_type_q;
	logic [POS_W-1:0]  record_length_q;

	logic              found_q;
	logic [POS_W-1:0]  pos_q;
	logic [63:0]       asm_q;
	logic              all_zero_q;
	logic              skipping_q;
	logic [SKIP_W-1:0] skip_rem_q;

	logic              found_d;
	logic [POS_W-1:0]  pos_d;
	logic [63:0]       asm_d;
	logic              all_zero_d;
	logic              skipping_d;
	logic [SKIP_W-1:0] skip_rem_d;

	logic              out_vld_q, skid_vld_q;
	logic              out_dat_q, skid_dat_q;

	logic              accept, push, pop, report;

	// Little-endian element assembly shared by the numeric types and the string length prefix.
	logic [63:0]       g_val;
	logic [POS_W-1:0]  g_pos;
	logic [POS_W-1:0]  g_size;
	logic              g_done;
	logic [POS_W-1:0]  rec_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_type_q   <= TYPE_BOOL;
			record_length_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_COLUMN_TYPE:   column_type_q   <= cfg_data[TYPE_W-1:0];
				REG_RECORD_LENGTH: record_length_q <= cfg_data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	assign accept = item.valid && item.ready;
	assign item.ready = !skid_vld_q;

	always_comb begin
		g_size = ((column_type_q == TYPE_INT64) || (column_type_q == TYPE_DOUBLE))
			? POS_W'(8) : POS_W'(4);
		g_val  = asm_q | (64'(item.data_byte) << {pos_q[2:0], 3'b000});
		g_pos  = pos_q + POS_W'(1);
		g_done = (g_pos >= g_size);
		rec_len = (record_length_q == '0) ? FIXED_DEFAULT_LEN : record_length_q;
	end

	always_comb begin
		found_d    = found_q;
		pos_d      = pos_q;
		asm_d      = asm_q;
		all_zero_d = all_zero_q;
		skipping_d = skipping_q;
		skip_rem_d = skip_rem_q;

		unique case (column_type_q) inside
			TYPE_BOOL: begin
				if (item.data_byte[7]) found_d = 1'b1;
			end
			TYPE_INT32, TYPE_INT64, TYPE_FLOAT, TYPE_DOUBLE: begin
				if (g_done) begin
					pos_d = '0;
					asm_d = '0;
					case (column_type_q)
						TYPE_INT32:
							if (g_val[31:0] == INT32_MIN_BITS) found_d = 1'b1;
						TYPE_INT64:
							if (g_val == INT64_MIN_BITS) found_d = 1'b1;
						TYPE_FLOAT:
							if ((&g_val[30:23]) && (g_val[22:0] != '0)) found_d = 1'b1;
						default:
							if ((&g_val[62:52]) && (g_val[51:0] != '0)) found_d = 1'b1;
					endcase
				end else begin
					pos_d = g_pos;
					asm_d = g_val;
				end
			end
			TYPE_STRING: begin
				if (skipping_q) begin
					skip_rem_d = skip_rem_q - SKIP_W'(1);
					if (skip_rem_d == '0) skipping_d = 1'b0;
				end else if (g_done) begin
					pos_d = '0;
					asm_d = '0;
					if (g_val[31:0] == '0) begin
						found_d = 1'b1;
					end else begin
						skipping_d = 1'b1;
						skip_rem_d = g_val[31:0];
					end
				end else begin
					pos_d = g_pos;
					asm_d = g_val;
				end
			end
			TYPE_FIXED: begin
				if (g_pos >= rec_len) begin
					// The record closes on this byte, so it counts toward the zero test.
					if (all_zero_q && (item.data_byte == '0)) found_d = 1'b1;
					pos_d      = '0;
					all_zero_d = 1'b1;
				end else begin
					pos_d = g_pos;
					if (item.data_byte != '0) all_zero_d = 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign report = item.empty_buffer ? 1'b1 : found_d;
	assign push   = accept && (item.empty_buffer || item.last_byte);
	assign pop    = out_vld_q && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q    <= 1'b0;
			pos_q      <= '0;
			asm_q      <= '0;
			all_zero_q <= 1'b1;
			skipping_q <= 1'b0;
			skip_rem_q <= '0;
		end else if (accept) begin
			if (item.empty_buffer || item.last_byte) begin
				found_q    <= 1'b0;
				pos_q      <= '0;
				asm_q      <= '0;
				all_zero_q <= 1'b1;
				skipping_q <= 1'b0;
				skip_rem_q <= '0;
			end else begin
				found_q    <= found_d;
				pos_q      <= pos_d;
				asm_q      <= asm_d;
				all_zero_q <= all_zero_d;
				skipping_q <= skipping_d;
				skip_rem_q <= skip_rem_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (pop) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= push;
			end else begin
				out_vld_q <= push;
			end
		end else if (push) begin
			if (out_vld_q) skid_vld_q <= 1'b1;
			else out_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_vld_q) begin
				out_dat_q <= skid_dat_q;
				if (push) skid_dat_q <= report;
			end else if (push) begin
				out_dat_q <= report;
			end
		end else if (push) begin
			if (out_vld_q) skid_dat_q <= report;
			else out_dat_q <= report;
		end
	end

	assign result.valid     = out_vld_q;
	assign result.null_seen = out_dat_q;

endmodule

`default_nettype wire

[hw/rtl/cnms_checker.sv]
// ----------------------------------------------------------------------------
// cnms_checker
// Port-level checks for the column null-marker scan, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cnms_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	input wire logic item_ready,
	input wire logic item_last,
	input wire logic item_empty,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire logic res_null_seen
);

	logic acc;

	assign acc = item_valid && item_ready;

	`ASSERT_CLKD(a_res_hold, clk, arst_n, (res_valid && !res_ready) |=> res_valid)
	`ASSERT_NEVER(a_stall_needs_report, clk, arst_n, !item_ready && !res_valid)
	// An empty buffer always reports a null on the next cycle when nothing is queued.
	`ASSERT_CLKD(a_empty_reports, clk, arst_n,
		(acc && item_empty && !res_valid) |=> (res_valid && res_null_seen))
	// A byte that is not the final one never produces a report.
	`ASSERT_CLKD(a_mid_silent, clk, arst_n,
		(acc && !item_empty && !item_last && !res_valid) |=> !res_valid)

endmodule

bind column_null_marker_scan_core cnms_checker u_cnms_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_valid    (item.valid),
	.item_ready    (item.ready),
	.item_last     (item.last_byte),
	.item_empty    (item.empty_buffer),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.res_null_seen (result.null_seen)
);

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the column null-marker scan core. Byte requests are
// streamed through the valid/ready input channel under random gaps and
// back-pressure. Each null report is checked against an in-bench scan model
// that tracks the same per-buffer state and register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top import cnms_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET    = 1450;
	localparam int PHASE_ITEMS    = 95;
	localparam int STALL_LEN      = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int IDLE_PCT       = 26;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       empty;
	} scan_req_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	cnms_in_if  item_ch ();
	cnms_out_if result_ch ();

	column_null_marker_scan_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.item     (item_ch),
		.result   (result_ch)
	);

	scan_req_t byte_queue[$];
	logic      null_expect[$];
	scan_req_t drv_req;
	int        reqs_outstanding = 0;
	int        items_sent       = 0;
	int        mismatches       = 0;
	int        quiet_cycles     = 0;
	int        src_idle_pct     = IDLE_PCT;
	int        sink_idle_pct    = IDLE_PCT;
	int        stalls_asked     = 0;
	int        stalls_done      = 0;
	int        stall_left       = 0;
	logic      byte_accepted    = 1'b0;

	// Scan model: register shadows and per-buffer state.
	logic [TYPE_W-1:0] col_type_shadow = TYPE_BOOL;
	logic [15:0]       rec_len_shadow  = '0;
	logic              scan_found;
	logic [POS_W-1:0]  scan_pos;
	logic [63:0]       scan_word;
	logic              scan_rec_zero;
	logic              scan_skipping;
	logic [SKIP_W-1:0] scan_skip_left;

	function automatic void clear_scan();
		scan_found     = 1'b0;
		scan_pos       = '0;
		scan_word      = '0;
		scan_rec_zero  = 1'b1;
		scan_skipping  = 1'b0;
		scan_skip_left = '0;
	endfunction

	// Little-endian assembly; the byte lane follows the low three position bits.
	function automatic bit gather_le(input logic [7:0] b, input int unsigned size,
			output logic [63:0] whole);
		scan_word = scan_word | (64'(b) << {scan_pos[2:0], 3'b000});
		scan_pos  = scan_pos + 16'd1;
		whole     = scan_word;
		if (32'(scan_pos) >= size) begin
			scan_word = '0;
			scan_pos  = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void scan_request(input scan_req_t req, output bit reports,
			output logic flag);
		logic [63:0] v;
		logic [31:0] rl;
		reports = 1'b0;
		flag    = 1'b0;
		if (req.empty) begin
			clear_scan();
			reports = 1'b1;
			flag    = 1'b1;
			return;
		end
		case (col_type_shadow)
			TYPE_BOOL: begin
				if (req.data[7])
					scan_found = 1'b1;
			end
			TYPE_INT32: begin
				if (gather_le(req.data, 4, v) && v[31:0] == INT32_MIN_BITS)
					scan_found = 1'b1;
			end
			TYPE_INT64: begin
				if (gather_le(req.data, 8, v) && v == INT64_MIN_BITS)
					scan_found = 1'b1;
			end
			TYPE_FLOAT: begin
				if (gather_le(req.data, 4, v) && v[30:23] == 8'hFF && v[22:0] != 0)
					scan_found = 1'b1;
			end
			TYPE_DOUBLE: begin
				if (gather_le(req.data, 8, v) && v[62:52] == 11'h7FF && v[51:0] != 0)
					scan_found = 1'b1;
			end
			TYPE_STRING: begin
				if (scan_skipping) begin
					scan_skip_left = scan_skip_left - 32'd1;
					if (scan_skip_left == 0)
						scan_skipping = 1'b0;
				end else if (gather_le(req.data, 4, v)) begin
					if (v[31:0] == 0) begin
						scan_found = 1'b1;
					end else begin
						scan_skipping  = 1'b1;
						scan_skip_left = v[31:0];
					end
				end
			end
			TYPE_FIXED: begin
				rl = (rec_len_shadow == 0) ? 32'(FIXED_DEFAULT_LEN) : 32'(rec_len_shadow);
				if (req.data != 0)
					scan_rec_zero = 1'b0;
				scan_pos = scan_pos + 16'd1;
				if (32'(scan_pos) >= rl) begin
					if (scan_rec_zero)
						scan_found = 1'b1;
					scan_pos      = '0;
					scan_rec_zero = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (!req.last)
			return;
		reports = 1'b1;
		flag    = scan_found;
		clear_scan();
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Model update and result checking, sampled on the rising edge.
	always @(posedge clk) begin
		bit   reports;
		logic flag;
		logic want;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_idx == REG_COLUMN_TYPE)
					col_type_shadow = cfg_data[TYPE_W-1:0];
				else if (cfg_idx == REG_RECORD_LENGTH)
					rec_len_shadow = cfg_data;
			end
			if (result_ch.valid && result_ch.ready) begin
				if (null_expect.size() == 0) begin
					$display("%0t ns: null_seen expected none, actual %0b", $time,
						result_ch.null_seen);
					mismatches++;
				end else begin
					want = null_expect.pop_front();
					if (result_ch.null_seen !== want) begin
						$display("%0t ns: null_seen expected %0b, actual %0b", $time, want,
							result_ch.null_seen);
						mismatches++;
					end
				end
			end
			if (item_ch.valid && item_ch.ready) begin
				reqs_outstanding--;
				scan_request('{item_ch.data_byte, item_ch.last_byte, item_ch.empty_buffer},
					reports, flag);
				if (reports)
					null_expect.push_back(flag);
			end
		end
		byte_accepted <= arst_n && item_ch.valid && item_ch.ready;
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("column_null_marker_scan_core regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Request driver: a request stays up until it is taken.
	always @(negedge clk) begin
		if (arst_n && (!item_ch.valid || byte_accepted)) begin
			if (byte_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				drv_req = byte_queue.pop_front();
				item_ch.valid        <= 1'b1;
				item_ch.data_byte    <= drv_req.data;
				item_ch.last_byte    <= drv_req.last;
				item_ch.empty_buffer <= drv_req.empty;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// Result sink with random back-pressure and long hold-offs on request.
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left      <= stall_left - 1;
			end else if (stalls_done != stalls_asked) begin
				result_ch.ready <= 1'b0;
				stall_left      <= STALL_LEN;
				stalls_done     <= stalls_done + 1;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	function automatic void queue_request(input logic [7:0] data, input logic last,
			input logic empty);
		byte_queue.push_back('{data, last, empty});
		reqs_outstanding++;
		items_sent++;
	endfunction

	function automatic logic [63:0] pick_word(input logic [TYPE_W-1:0] t, input int kind);
		logic [63:0] w;
		w = {$urandom, $urandom};
		case (t)
			TYPE_BOOL: w[7] = (kind == 0);
			TYPE_INT32: begin
				if (kind == 0)
					w[31:0] = INT32_MIN_BITS;
				else if (kind == 1)
					w[31:0] = INT32_MIN_BITS ^ (32'h1 << $urandom_range(31));
			end
			TYPE_INT64: begin
				if (kind == 0)
					w = INT64_MIN_BITS;
				else if (kind == 1)
					w = INT64_MIN_BITS ^ (64'h1 << $urandom_range(63));
			end
			TYPE_FLOAT: begin
				// A NaN needs a nonzero mantissa; an infinity is the near miss.
				if (kind == 0) begin
					w[30:23] = 8'hFF;
					if (w[22:0] == 0)
						w[0] = 1'b1;
				end else if (kind == 1) begin
					w[30:23] = 8'hFF;
					w[22:0]  = '0;
				end
			end
			TYPE_DOUBLE: begin
				if (kind == 0) begin
					w[62:52] = 11'h7FF;
					if (w[51:0] == 0)
						w[0] = 1'b1;
				end else if (kind == 1) begin
					w[62:52] = 11'h7FF;
					w[51:0]  = '0;
				end
			end
			TYPE_STRING: begin
				if (kind == 0)
					w[31:0] = '0;
				else if (kind < 3 || $urandom_range(3) != 0)
					w[31:0] = $urandom_range(1, 6);
			end
			default: begin
			end
		endcase
		return w;
	endfunction

	// One column buffer of whole elements with random content, sometimes with a
	// trailing partial element or cut short by an empty-buffer request.
	task automatic add_buffer(input logic [TYPE_W-1:0] t, input int rl);
		logic [7:0]  bytes[$];
		logic [63:0] w;
		int          n_elem;
		int          width;
		int          kind;
		int          hot;
		int          k;
		bit          cut;
		n_elem = ($urandom_range(7) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 4);
		cut    = 1'b0;
		for (int e = 0; e < n_elem && !cut; e++) begin
			kind = $urandom_range(3);
			if (t == TYPE_FIXED) begin
				hot = $urandom_range(rl - 1);
				for (k = 0; k < rl && k < 24; k++) begin
					if (kind == 0)
						bytes.push_back(8'h00);
					else if (kind == 1)
						bytes.push_back((k == hot) ? 8'($urandom_range(1, 255)) : 8'h00);
					else
						bytes.push_back(8'($urandom));
				end
			end else begin
				w = pick_word(t, kind);
				case (t) inside
					TYPE_BOOL, TYPE_OTHER: width = 1;
					TYPE_INT32, TYPE_FLOAT, TYPE_STRING: width = 4;
					default: width = 8;
				endcase
				for (k = 0; k < width; k++)
					bytes.push_back(w[8*k +: 8]);
				if (t == TYPE_STRING && w[31:0] != 0) begin
					if (w[31:0] <= 6) begin
						for (k = 0; k < int'(w[31:0]); k++)
							bytes.push_back(8'($urandom));
					end else begin
						// A long payload runs past the end of the buffer.
						repeat ($urandom_range(6))
							bytes.push_back(8'($urandom));
						cut = 1'b1;
					end
				end
			end
		end
		if ($urandom_range(4) == 0)
			repeat ($urandom_range(1, 3))
				bytes.push_back(8'($urandom));
		if (bytes.size() == 0)
			bytes.push_back(8'($urandom));
		if ($urandom_range(11) == 0) begin
			k = $urandom_range(bytes.size() - 1);
			for (int i = 0; i < k; i++)
				queue_request(bytes[i], 1'b0, 1'b0);
			queue_request(8'($urandom), 1'($urandom_range(1)), 1'b1);
		end else begin
			for (int i = 0; i < bytes.size(); i++)
				queue_request(bytes[i], i == bytes.size() - 1, 1'b0);
		end
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits for every request to be taken and every report to arrive, then lets
	// the last byte settle before any register write.
	task automatic settle();
		while (reqs_outstanding != 0 || null_expect.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		int                    p;
		int                    phase_end;
		logic [TYPE_W-1:0]     ctype;
		logic [15:0]           rlen;
		logic [CFG_DATA_W-1:0] type_word;

		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_idx              = '0;
		cfg_data             = '0;
		item_ch.valid        = 1'b0;
		item_ch.data_byte    = '0;
		item_ch.last_byte    = 1'b0;
		item_ch.empty_buffer = 1'b0;
		result_ch.ready      = 1'b0;
		clear_scan();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Boolean column from reset, including empty buffers with and without
		// the final-byte mark, one of them after pending bytes.
		queue_request(8'h7F, 1'b0, 1'b0);
		queue_request(8'hFF, 1'b1, 1'b0);
		queue_request(8'h00, 1'b1, 1'b0);
		queue_request(8'h12, 1'b0, 1'b0);
		queue_request(8'h34, 1'b0, 1'b1);
		queue_request(8'h56, 1'b1, 1'b1);
		settle();
		set_reg(REG_COLUMN_TYPE, CFG_DATA_W'(TYPE_INT32));
		@(posedge clk);
		queue_request(8'h00, 1'b0, 1'b0);
		queue_request(8'h00, 1'b0, 1'b0);
		queue_request(8'h00, 1'b0, 1'b0);
		queue_request(8'h80, 1'b1, 1'b0);
		settle();
		set_reg(REG_COLUMN_TYPE, CFG_DATA_W'(TYPE_FLOAT));
		@(posedge clk);
		queue_request(8'h01, 1'b0, 1'b0);
		queue_request(8'h00, 1'b0, 1'b0);
		queue_request(8'h80, 1'b0, 1'b0);
		queue_request(8'hFF, 1'b1, 1'b0);
		settle();
		set_reg(REG_COLUMN_TYPE, CFG_DATA_W'(TYPE_STRING));
		@(posedge clk);
		repeat (3) queue_request(8'h00, 1'b0, 1'b0);
		queue_request(8'h00, 1'b1, 1'b0);
		settle();
		// Type change in the middle of a buffer: six bytes into a 64-bit element,
		// the switch to 32-bit closes the element on the next byte.
		set_reg(REG_COLUMN_TYPE, CFG_DATA_W'(TYPE_INT64));
		@(posedge clk);
		repeat (6) queue_request(8'h00, 1'b0, 1'b0);
		settle();
		set_reg(REG_COLUMN_TYPE, CFG_DATA_W'(TYPE_INT32));
		@(posedge clk);
		queue_request(8'h80, 1'b1, 1'b0);

		p = 0;
		while (items_sent < ITEM_TARGET) begin
			settle();
			ctype = (p < 8) ? 3'(p) : 3'($urandom_range(7));
			case ($urandom_range(5))
				0: rlen = '0;
				1: rlen = 16'd1;
				default: rlen = 16'($urandom_range(2, 12));
			endcase
			if (p == 6)
				rlen = '0;
			if (p == 9) begin
				ctype = TYPE_FIXED;
				rlen  = 16'hFFFF;
			end
			if (p == 10) begin
				ctype = TYPE_FIXED;
				rlen  = 16'd1;
			end
			type_word              = CFG_DATA_W'($urandom);
			type_word[TYPE_W-1:0]  = ctype;
			set_reg(REG_COLUMN_TYPE, type_word);
			set_reg(REG_RECORD_LENGTH, rlen);
			src_idle_pct  = (p == 5) ? 0 : IDLE_PCT;
			sink_idle_pct = (p == 5) ? 0 : IDLE_PCT;
			@(posedge clk);
			phase_end = items_sent + PHASE_ITEMS;
			if (p == 3) begin
				// One-byte buffers pile up reports while the sink holds off.
				while (items_sent < phase_end)
					queue_request(8'($urandom), 1'b1, 1'($urandom_range(15) == 0));
				stalls_asked++;
			end else begin
				while (items_sent < phase_end)
					add_buffer(ctype, (rlen == 0) ? 16 : int'(rlen));
			end
			// Leave a partial buffer open across the next register change.
			if (p % 3 == 2)
				repeat ($urandom_range(1, 5))
					queue_request(8'($urandom), 1'b0, 1'b0);
			p++;
		end

		settle();
		repeat (10) @(negedge clk);
		if (mismatches == 0 && null_expect.size() == 0)
			$display("column_null_marker_scan_core regression: pass");
		else
			$display("column_null_marker_scan_core regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
